FILE: rtl/ttcs_pkg.sv
// shared definitions for the text terminal cursor and scroll unit
// operation codes, character codes, write select codes and the control/status structs
// no dependencies
package ttcs_pkg;

   // default screen geometry
   localparam int DEF_WIDTH  = 80;
   localparam int DEF_HEIGHT = 5;

   // operation codes
   localparam logic [1:0] OP_PUT    = 2'd0;
   localparam logic [1:0] OP_PROMPT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   // character and attribute codes
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_PROMPT     = 8'h3E;
   localparam logic [7:0] CHAR_CURSOR     = 8'h5F;
   localparam logic [7:0] RESET_ATTRIBUTE = 8'h07;

   // cell store write source
   localparam logic [2:0] WSEL_CHAR   = 3'd0;
   localparam logic [2:0] WSEL_PROMPT = 3'd1;
   localparam logic [2:0] WSEL_CURSOR = 3'd2;
   localparam logic [2:0] WSEL_SWEEP  = 3'd3;
   localparam logic [2:0] WSEL_COPY   = 3'd4;
   localparam logic [2:0] WSEL_BLANK  = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic       latch;
      logic       wr_en;
      logic [2:0] wr_sel;
      logic       rd_en;
      logic       rd_copy;
      logic       sweep_reset_attr;
      logic       cnt_inc;
      logic       cnt_clr;
      logic       col_inc;
      logic       col_zero;
      logic       row_advance;
      logic       cursor_reset;
      logic       shifted_set;
      logic       load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       newline;
      logic       col_last;
      logic       need_scroll;
      logic       sweep_last;
      logic       copy_last;
      logic       cnt_zero;
      logic       blank_last;
      logic       rsp_free;
   } status_type;

endpackage

FILE: rtl/ttcs_ctrl.sv
// controller state machine of the text terminal unit
// sequences cell store sweeps, scrolls and result hand-off; depends on ttcs_pkg
module ttcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ttcs_pkg::status_type status,
   output ttcs_pkg::cmd_type    cmd
);
   import ttcs_pkg::*;

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_EXEC   = 4'd2;
   localparam logic [3:0] ST_ADV    = 4'd3;
   localparam logic [3:0] ST_SCROLL = 4'd4;
   localparam logic [3:0] ST_BLANK  = 4'd5;
   localparam logic [3:0] ST_PROMPT = 4'd6;
   localparam logic [3:0] ST_CLEAR  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.wr_en            = 1'b1;
            cmd.wr_sel           = WSEL_SWEEP;
            cmd.sweep_reset_attr = 1'b1;
            if (status.sweep_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (status.op)
               OP_PUT: begin
                  if (status.newline) begin
                     cmd.col_zero = 1'b1;
                     state_in     = ST_ADV;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WSEL_CHAR;
                     if (status.col_last) begin
                        cmd.col_zero = 1'b1;
                        state_in     = ST_ADV;
                     end else begin
                        cmd.col_inc = 1'b1;
                        // plain character finishes here when the output slot is free
                        if (status.rsp_free) begin
                           cmd.load_rsp = 1'b1;
                           state_in     = ST_IDLE;
                        end else begin
                           state_in = ST_DONE;
                        end
                     end
                  end
               end
               OP_PROMPT: begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WSEL_PROMPT;
                  state_in   = ST_PROMPT;
               end
               OP_CLEAR: begin
                  cmd.cursor_reset = 1'b1;
                  state_in         = ST_CLEAR;
               end
               OP_READ: begin
                  cmd.rd_en = 1'b1;
                  state_in  = ST_DONE;
               end
            endcase
         end
         ST_ADV: begin
            cmd.row_advance = 1'b1;
            if (status.need_scroll) begin
               cmd.shifted_set = 1'b1;
               state_in        = ST_SCROLL;
            end else begin
               state_in = ST_BLANK;
            end
         end
         ST_SCROLL: begin
            // read one row ahead, write back in the next cycle
            cmd.rd_en   = !status.copy_last;
            cmd.rd_copy = 1'b1;
            cmd.wr_en   = !status.cnt_zero;
            cmd.wr_sel  = WSEL_COPY;
            if (status.copy_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_BLANK;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_BLANK: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WSEL_BLANK;
            if (status.blank_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_PROMPT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WSEL_CURSOR;
            state_in   = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WSEL_SWEEP;
            if (status.sweep_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

FILE: rtl/ttcs_dpath.sv
// datapath of the text terminal unit: cell store, cursor, sweep counter, output register
// driven by ttcs_ctrl through cmd_type; depends on ttcs_pkg
module ttcs_dpath #(
   parameter int WIDTH  = ttcs_pkg::DEF_WIDTH,
   parameter int HEIGHT = ttcs_pkg::DEF_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [7:0]           csr_write_data,
   input  logic [1:0]           req_operation,
   input  logic [7:0]           req_character,
   input  logic [8:0]           req_read_address,
   input  ttcs_pkg::cmd_type    cmd,
   output ttcs_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_cursor_row,
   output logic [6:0]           rsp_cursor_column,
   output logic [15:0]          rsp_cell_data,
   output logic                 rsp_lines_shifted
);
   import ttcs_pkg::*;

   localparam int CELLS    = WIDTH * HEIGHT;
   localparam int AW       = $clog2(CELLS);
   localparam int RW       = $clog2(HEIGHT);
   localparam int CW       = $clog2(WIDTH);
   // one bit above both the address and the cell count so the range compare never wraps
   localparam int EW       = ((AW > 9) ? AW : 9) + 1;
   localparam int COPY_LEN = (HEIGHT - 2) * WIDTH;

   // cell store
   logic [15:0] cells_mem [CELLS];
   logic [15:0] rdata_ff;

   // control state
   logic [7:0]    attribute_ff, attribute_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic          wrapped_ff, wrapped_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // latched word and per-item flags
   logic [1:0]    op_ff;
   logic [7:0]    char_ff;
   logic [AW-1:0] addr_ff;
   logic          in_range_ff;
   logic          shifted_ff;

   // output payload
   logic [2:0]  rsp_row_ff;
   logic [6:0]  rsp_col_ff;
   logic [15:0] rsp_data_ff;
   logic        rsp_shifted_ff;

   logic [AW-1:0] row_base;
   logic [AW-1:0] base;
   logic [AW:0]   base1;
   logic          base1_ok;
   logic [RW:0]   row_next_w;
   logic          bottom_zone;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_char;
   logic [7:0]    wr_attr;
   logic [15:0]   wr_data;
   logic          wr_go;
   logic [AW-1:0] rd_addr;
   logic [7:0]    sweep_char;

   // cursor addressing
   assign row_base = AW'(row_ff) * AW'(WIDTH);
   assign base     = row_base + AW'(col_ff);
   assign base1    = {1'b0, base} + (AW+1)'(1);
   assign base1_ok = base1 < (AW+1)'(CELLS);

   assign row_next_w  = {1'b0, row_ff} + (RW+1)'(1);
   assign bottom_zone = row_next_w >= (RW+1)'(HEIGHT - 1);

   // start-up pattern: prompt at the origin, cursor mark after it, spaces elsewhere
   always_comb begin
      priority if (cnt_ff == AW'(0)) begin
         sweep_char = CHAR_PROMPT;
      end else if (cnt_ff == AW'(1)) begin
         sweep_char = CHAR_CURSOR;
      end else begin
         sweep_char = CHAR_SPACE;
      end
   end

   assign wr_attr = cmd.sweep_reset_attr ? RESET_ATTRIBUTE : attribute_ff;

   always_comb begin
      unique case (cmd.wr_sel)
         WSEL_CHAR: begin
            wr_addr = base;
            wr_char = char_ff;
         end
         WSEL_PROMPT: begin
            wr_addr = base;
            wr_char = CHAR_PROMPT;
         end
         WSEL_CURSOR: begin
            wr_addr = base1[AW-1:0];
            wr_char = CHAR_CURSOR;
         end
         WSEL_SWEEP: begin
            wr_addr = cnt_ff;
            wr_char = sweep_char;
         end
         WSEL_COPY: begin
            wr_addr = cnt_ff - AW'(1);
            wr_char = CHAR_SPACE;
         end
         WSEL_BLANK: begin
            wr_addr = row_base + cnt_ff;
            wr_char = CHAR_SPACE;
         end
         default: begin
            wr_addr = base;
            wr_char = CHAR_SPACE;
         end
      endcase
   end

   assign wr_data = (cmd.wr_sel == WSEL_COPY) ? rdata_ff : {wr_attr, wr_char};
   // the cursor half of a prompt past the last cell is dropped
   assign wr_go   = cmd.wr_en && ((cmd.wr_sel != WSEL_CURSOR) || base1_ok);
   assign rd_addr = cmd.rd_copy ? (cnt_ff + AW'(WIDTH)) : addr_ff;

   always_ff @(posedge clock) begin
      if (wr_go) begin
         cells_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= cells_mem[rd_addr];
      end
   end

   // next state of attribute, cursor, counter and output slot
   always_comb begin
      attribute_in = csr_write_enable ? csr_write_data : attribute_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      wrapped_in   = wrapped_ff;
      if (cmd.col_zero) begin
         col_in = '0;
      end else if (cmd.col_inc) begin
         col_in = col_ff + CW'(1);
      end
      if (cmd.row_advance) begin
         if (!bottom_zone) begin
            row_in = row_next_w[RW-1:0];
         end else if (!wrapped_ff) begin
            wrapped_in = 1'b1;
            row_in     = RW'(HEIGHT - 1);
         end else begin
            row_in = RW'(HEIGHT - 2);
         end
      end
      if (cmd.cursor_reset) begin
         row_in     = '0;
         col_in     = '0;
         wrapped_in = 1'b0;
      end
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + AW'(1);
      end else begin
         cnt_in = cnt_ff;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attribute_ff <= RESET_ATTRIBUTE;
         row_ff       <= '0;
         col_ff       <= '0;
         wrapped_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         attribute_ff <= attribute_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         wrapped_ff   <= wrapped_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff       <= req_operation;
         char_ff     <= req_character;
         addr_ff     <= AW'(req_read_address);
         in_range_ff <= EW'(req_read_address) < EW'(CELLS);
         shifted_ff  <= 1'b0;
      end else if (cmd.shifted_set) begin
         shifted_ff <= 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_row_ff     <= 3'(row_in);
         rsp_col_ff     <= 7'(col_in);
         rsp_data_ff    <= ((op_ff == OP_READ) && in_range_ff) ? rdata_ff : 16'h0000;
         rsp_shifted_ff <= shifted_ff;
      end
   end

   assign status.op          = op_ff;
   assign status.newline     = (char_ff == CHAR_NEWLINE);
   assign status.col_last    = (col_ff == CW'(WIDTH - 1));
   assign status.need_scroll = bottom_zone && wrapped_ff;
   assign status.sweep_last  = (cnt_ff == AW'(CELLS - 1));
   assign status.copy_last   = (cnt_ff == AW'(COPY_LEN));
   assign status.cnt_zero    = (cnt_ff == AW'(0));
   assign status.blank_last  = (cnt_ff == AW'(WIDTH - 1));
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cell_data     = rsp_data_ff;
   assign rsp_lines_shifted = rsp_shifted_ff;

endmodule

FILE: rtl/text_terminal_cursor_scroll_unit.sv
// top level of the text terminal cursor and scroll unit
// joins ttcs_ctrl and ttcs_dpath; depends on ttcs_pkg

// A text-mode terminal holding a WIDTH by HEIGHT store of 16-bit cells (attribute
// byte high, character byte low). Each request word gives exactly one response word
// with the cursor after the operation. One word is worked on at a time, and every
// cell store write goes through its single write port: a newline or a wrap blanks
// the new row, a wrap that shifts rows first copies rows up, and a clear rewrites
// every cell. After reset a clearing pass writes the start-up screen while req_ready
// stays low. A finished response waits in an output register, so the next request
// word can be taken while it is pending. The attribute register may be written at
// any cycle the unit is idle and colours every cell written afterwards; cells moved
// up by a row copy keep their own attribute.
module text_terminal_cursor_scroll_unit #(
   parameter int WIDTH  = ttcs_pkg::DEF_WIDTH,
   parameter int HEIGHT = ttcs_pkg::DEF_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   // attribute register write
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   // request words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_character,
   input  logic [8:0]  req_read_address,
   // response words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_column,
   output logic [15:0] rsp_cell_data,
   output logic        rsp_lines_shifted
);
   import ttcs_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: start-up sweep, per-operation steps, row copy, row blanking
   ttcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // cell store, cursor, attribute register and response register
   ttcs_dpath #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_operation     (req_operation),
      .req_character     (req_character),
      .req_read_address  (req_read_address),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cell_data     (rsp_cell_data),
      .rsp_lines_shifted (rsp_lines_shifted)
   );

endmodule

FILE: rtl/ttcs_checker.sv
// port-level checks for the text terminal unit, bound to the top level
// no package dependency
module ttcs_checker #(
   parameter int WIDTH  = 80,
   parameter int HEIGHT = 5
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_cursor_row,
   input logic [6:0]  rsp_cursor_column,
   input logic [15:0] rsp_cell_data,
   input logic        rsp_lines_shifted
);

   // a stalled response word holds
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_row)
         && $stable(rsp_cursor_column) && $stable(rsp_cell_data)
         && $stable(rsp_lines_shifted))
      else $error("response word changed while stalled");

   // one word at a time: ready drops right after an accept
   one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous word in flight");

   // a row shift always leaves the cursor at column 0 of the second-to-last row
   shift_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lines_shifted |->
         rsp_cursor_row == 3'(HEIGHT - 2) && rsp_cursor_column == 7'd0)
      else $error("row shift with cursor off the scroll row");

   // cursor column stays inside the screen
   column_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 8'(rsp_cursor_column) < 8'(WIDTH))
      else $error("cursor column beyond screen width");

endmodule

bind text_terminal_cursor_scroll_unit ttcs_checker #(
   .WIDTH  (WIDTH),
   .HEIGHT (HEIGHT)
) u_ttcs_checker (.*);

FILE: dv/tb.sv
// self-checking testbench for text_terminal_cursor_scroll_unit
// drives request words and attribute writes, predicts every response word in-line
// depends on rtl/ttcs_pkg.sv and rtl/text_terminal_cursor_scroll_unit.sv
module tb;
   import ttcs_pkg::*;

   localparam int CLK_PERIOD = 12;
   localparam int WIDTH      = DEF_WIDTH;
   localparam int HEIGHT     = DEF_HEIGHT;
   localparam int CELLS      = WIDTH * HEIGHT;
   // longest single word is a clear, so this covers any straggler at the end
   localparam int TAIL_CYCLES = CELLS + 100;
   localparam int HOLD_CYCLES = 1500;

   typedef struct packed {
      logic [2:0]  row;
      logic [6:0]  col;
      logic [15:0] data;
      logic        shifted;
   } cursor_report_type;

   // one directed stimulus row; typed rows carry a hand-written expectation
   typedef struct packed {
      logic [1:0]        op;
      logic [7:0]        ch;
      logic [8:0]        addr;
      logic              typed;
      cursor_report_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = 8'h00;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_PUT;
   logic [7:0]  req_character = 8'h00;
   logic [8:0]  req_read_address = 9'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_cursor_row;
   logic [6:0]  rsp_cursor_column;
   logic [15:0] rsp_cell_data;
   logic        rsp_lines_shifted;

   // shadow of the terminal: cells, cursor, wrap flag, attribute
   logic [15:0]  term_cells [0:CELLS-1];
   int unsigned  term_row;
   int unsigned  term_col;
   bit           term_wrapped;
   logic [7:0]   attr_shadow;

   cursor_report_type cursor_reports_due [$];
   int unsigned    items_sent = 0;
   int unsigned    mismatches = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_idle_pct = 0;
   // long receiver hold-off: stimulus side bumps the ask count, receiver side serves it
   int unsigned    hold_asks = 0;
   int unsigned    hold_served = 0;
   int unsigned    hold_left = 0;

   text_terminal_cursor_scroll_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_character     (req_character),
      .req_read_address  (req_read_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cell_data     (rsp_cell_data),
      .rsp_lines_shifted (rsp_lines_shifted)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // terminal predictor
   // ------------------------------------------------------------------

   // writes past the end of the store are dropped
   function automatic void put_cell(input int unsigned idx, input logic [7:0] ch);
      if (idx < CELLS) begin
         term_cells[idx] = {attr_shadow, ch};
      end
   endfunction

   // ">_" at the cursor, addressed linearly so '_' may spill to the next row
   function automatic void stamp_prompt();
      put_cell(term_row * WIDTH + term_col, CHAR_PROMPT);
      put_cell(term_row * WIDTH + term_col + 1, CHAR_CURSOR);
   endfunction

   function automatic void home_screen();
      term_row = 0;
      term_col = 0;
      term_wrapped = 1'b0;
      for (int i = 0; i < CELLS; i++) begin
         put_cell(i, CHAR_SPACE);
      end
      stamp_prompt();
   endfunction

   // scroll rule; returns 1 when rows moved up
   function automatic bit next_line();
      bit moved;
      moved = 1'b0;
      if (term_row + 1 >= HEIGHT - 1) begin
         if (term_wrapped) begin
            // rows 1..HEIGHT-2 move up, the last row is left alone
            for (int i = 0; i < (HEIGHT - 2) * WIDTH; i++) begin
               term_cells[i] = term_cells[i + WIDTH];
            end
            term_row = HEIGHT - 2;
            moved = 1'b1;
         end else begin
            // first scroll past the second-to-last row lands on the last row
            term_wrapped = 1'b1;
            term_row = term_row + 1;
         end
      end else begin
         term_row = term_row + 1;
      end
      for (int x = 0; x < WIDTH; x++) begin
         put_cell(term_row * WIDTH + x, CHAR_SPACE);
      end
      return moved;
   endfunction

   function automatic cursor_report_type run_terminal_op(input logic [1:0] op,
                                                         input logic [7:0] ch,
                                                         input logic [8:0] addr);
      cursor_report_type r;
      r = '0;
      case (op)
         OP_PUT: begin
            if (ch == CHAR_NEWLINE) begin
               term_col = 0;
               r.shifted = next_line();
            end else begin
               put_cell(term_row * WIDTH + term_col, ch);
               term_col = term_col + 1;
               if (term_col >= WIDTH) begin
                  term_col = 0;
                  r.shifted = next_line();
               end
            end
         end
         OP_PROMPT: stamp_prompt();
         OP_CLEAR: home_screen();
         OP_READ: begin
            // out-of-range reads give zero
            if (addr < CELLS) begin
               r.data = term_cells[addr];
            end
         end
      endcase
      r.row = 3'(term_row);
      r.col = 7'(term_col);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // directed rows: start-up screen, extremes, newline, wrap, shift, clear
   // ------------------------------------------------------------------
   stim_row_type directed_rows [0:22] = '{
      // start-up screen: prompt at the origin, cursor mark after it, spaces elsewhere
      '{OP_READ,   8'hFF, 9'd0,   1'b1, '{3'd0, 7'd0, 16'h073E, 1'b0}},
      '{OP_READ,   8'h00, 9'd1,   1'b1, '{3'd0, 7'd0, 16'h075F, 1'b0}},
      '{OP_READ,   8'h00, 9'd399, 1'b1, '{3'd0, 7'd0, 16'h0720, 1'b0}},
      // reads beyond the store return zero
      '{OP_READ,   8'h00, 9'd400, 1'b1, '{3'd0, 7'd0, 16'h0000, 1'b0}},
      '{OP_READ,   8'h00, 9'd511, 1'b1, '{3'd0, 7'd0, 16'h0000, 1'b0}},
      // character extremes
      '{OP_PUT,    8'h41, 9'h1FF, 1'b1, '{3'd0, 7'd1, 16'h0000, 1'b0}},
      '{OP_PUT,    8'hFF, 9'h000, 1'b1, '{3'd0, 7'd2, 16'h0000, 1'b0}},
      '{OP_PUT,    8'h00, 9'h1FF, 1'b1, '{3'd0, 7'd3, 16'h0000, 1'b0}},
      '{OP_READ,   8'h00, 9'd1,   1'b1, '{3'd0, 7'd3, 16'h07FF, 1'b0}},
      '{OP_READ,   8'hFF, 9'd2,   1'b1, '{3'd0, 7'd3, 16'h0700, 1'b0}},
      // prompt leaves the cursor where it is
      '{OP_PROMPT, 8'hA5, 9'h1FF, 1'b1, '{3'd0, 7'd3, 16'h0000, 1'b0}},
      '{OP_READ,   8'h00, 9'd3,   1'b1, '{3'd0, 7'd3, 16'h073E, 1'b0}},
      // newlines walk down, the last one without shifting sets the wrap flag
      '{OP_PUT,    CHAR_NEWLINE, 9'd0, 1'b1, '{3'd1, 7'd0, 16'h0000, 1'b0}},
      '{OP_PUT,    CHAR_NEWLINE, 9'd0, 1'b1, '{3'd2, 7'd0, 16'h0000, 1'b0}},
      '{OP_PUT,    CHAR_NEWLINE, 9'd0, 1'b1, '{3'd3, 7'd0, 16'h0000, 1'b0}},
      '{OP_PUT,    CHAR_NEWLINE, 9'd0, 1'b1, '{3'd4, 7'd0, 16'h0000, 1'b0}},
      '{OP_PUT,    8'h7A, 9'd0,   1'b1, '{3'd4, 7'd1, 16'h0000, 1'b0}},
      // wrapped already: rows shift and the cursor parks on the second-to-last row
      '{OP_PUT,    CHAR_NEWLINE, 9'd0, 1'b1, '{3'd3, 7'd0, 16'h0000, 1'b1}},
      // last row survives the shift
      '{OP_READ,   8'h00, 9'd320, 1'b1, '{3'd3, 7'd0, 16'h077A, 1'b0}},
      '{OP_READ,   8'h00, 9'd0,   1'b0, '0},
      // clear restores the start-up screen
      '{OP_CLEAR,  8'hFF, 9'h1FF, 1'b1, '{3'd0, 7'd0, 16'h0000, 1'b0}},
      '{OP_READ,   8'h00, 9'd0,   1'b1, '{3'd0, 7'd0, 16'h073E, 1'b0}},
      '{OP_READ,   8'h00, 9'd4,   1'b0, '0}
   };

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offer one word, hold it until taken, then log its expected response
   task automatic offer_word(input logic [1:0] op, input logic [7:0] ch,
                             input logic [8:0] addr, input bit typed,
                             input cursor_report_type want);
      cursor_report_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_character    <= ch;
      req_read_address <= addr;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predicted = run_terminal_op(op, ch, addr);
      cursor_reports_due.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic offer_op(input logic [1:0] op, input logic [7:0] ch,
                           input logic [8:0] addr);
      offer_word(op, ch, addr, 1'b0, '0);
   endtask

   // sender goes quiet until every response word is back
   task automatic drain_replies(input int unsigned extra);
      req_valid <= 1'b0;
      while (cursor_reports_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_attribute(input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      attr_shadow = value;
   endtask

   function automatic logic [8:0] pick_address();
      // mostly inside the store, sometimes past its end
      if ($urandom_range(9) != 0) begin
         return 9'($urandom_range(CELLS - 1));
      end
      return 9'($urandom_range(511, CELLS));
   endfunction

   function automatic logic [7:0] pick_glyph();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      return (c == CHAR_NEWLINE) ? 8'h21 : c;
   endfunction

   // one random sequence: mostly text lines, with scrolls, reads, prompts and noise
   task automatic random_burst();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(99);
      if ($urandom_range(49) == 0) begin
         drain_replies(0);
      end
      if (pick < 45) begin
         // line of text, occasionally long enough to wrap at the right edge
         n = ($urandom_range(9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 16);
         repeat (n) offer_op(OP_PUT, 8'($urandom_range(255)), pick_address());
         if ($urandom_range(9) < 6) begin
            offer_op(OP_PUT, CHAR_NEWLINE, pick_address());
         end
      end else if (pick < 60) begin
         repeat ($urandom_range(1, 4)) offer_op(OP_PUT, CHAR_NEWLINE, pick_address());
      end else if (pick < 75) begin
         repeat ($urandom_range(1, 4)) offer_op(OP_READ, 8'($urandom_range(255)),
                                                pick_address());
      end else if (pick < 85) begin
         offer_op(OP_PROMPT, 8'($urandom_range(255)), pick_address());
      end else if (pick < 88) begin
         offer_op(OP_CLEAR, 8'($urandom_range(255)), pick_address());
      end else if (pick < 93) begin
         // prompt at the right edge, sometimes on the last row so '_' falls off the end
         if ($urandom_range(2) == 0) begin
            offer_op(OP_CLEAR, 8'h00, 9'd0);
            repeat (HEIGHT - 1) offer_op(OP_PUT, CHAR_NEWLINE, 9'd0);
         end
         while (term_col != WIDTH - 1) begin
            offer_op(OP_PUT, pick_glyph(), pick_address());
         end
         offer_op(OP_PROMPT, 8'($urandom_range(255)), pick_address());
         offer_op(OP_READ, 8'h00, 9'(term_row * WIDTH + term_col));
         offer_op(OP_READ, 8'h00, 9'(term_row * WIDTH + term_col + 1));
         offer_op(OP_READ, 8'h00, 9'(CELLS - 1));
      end else begin
         // noise: anything the fields allow
         repeat ($urandom_range(1, 3)) offer_op(2'($urandom_range(3)),
                                                8'($urandom_range(255)),
                                                9'($urandom_range(511)));
      end
   endtask

   // one phase: set the attribute while idle, then random words
   task automatic run_phase(input logic [7:0] attr, input int unsigned tx_idle,
                            input int unsigned rx_idle, input int unsigned count,
                            input bit long_hold);
      int unsigned stop_at;
      write_attribute(attr);
      send_idle_pct = tx_idle;
      recv_idle_pct = rx_idle;
      stop_at = items_sent + count;
      if (long_hold) begin
         // receiver stops; keep feeding plain characters so the unit backs up
         hold_asks <= hold_asks + 1;
         repeat (40) offer_op(OP_PUT, 8'($urandom_range(32, 126)), pick_address());
      end
      while (items_sent < stop_at) begin
         random_burst();
      end
      drain_replies(8);
   endtask

   initial begin : stimulus
      attr_shadow = RESET_ATTRIBUTE;
      home_screen();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part with the reset attribute
      foreach (directed_rows[i]) begin
         offer_word(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].addr,
                    directed_rows[i].typed, directed_rows[i].want);
      end
      drain_replies(8);

      // attribute extremes first, then random values
      run_phase(8'hFF, 14, 55, 450, 1'b0);
      run_phase(8'h00, 55, 14, 450, 1'b0);
      run_phase(8'($urandom_range(255)), 0, 0, 450, 1'b0);
      run_phase(8'($urandom_range(255)), 0, 0, 450, 1'b1);

      drain_replies(TAIL_CYCLES);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // response side: random back-pressure, long hold-off, field checks
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      cursor_report_type want;
      if (hold_served != hold_asks) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end

      if (!reset && rsp_valid && rsp_ready) begin
         if (cursor_reports_due.size() == 0) begin
            $error("response word with nothing expected");
            mismatches++;
         end else begin
            want = cursor_reports_due.pop_front();
            if (rsp_cursor_row !== want.row) begin
               $error("cursor_row expected %0d got %0d", want.row, rsp_cursor_row);
               mismatches++;
            end
            if (rsp_cursor_column !== want.col) begin
               $error("cursor_column expected %0d got %0d", want.col, rsp_cursor_column);
               mismatches++;
            end
            if (rsp_cell_data !== want.data) begin
               $error("cell_data expected %h got %h", want.data, rsp_cell_data);
               mismatches++;
            end
            if (rsp_lines_shifted !== want.shifted) begin
               $error("lines_shifted expected %0d got %0d", want.shifted,
                      rsp_lines_shifted);
               mismatches++;
            end
         end
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #(CLK_PERIOD * 8000000);
      $display("tb NOT OK");
      $finish;
   end

endmodule
